FILE: rtl/bcsl_pkg.sv
package bcsl_pkg;

	localparam int CODE_W    = 8;
	localparam int TIME_W    = 16;
	localparam int ELAPSED_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int S_DATA_W  = 24;
	localparam int M_DATA_W  = 8;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

	// request kinds carried on s_tuser
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLARITY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_GAP  = 3'd4;

	typedef struct packed {
		logic              enabled;
		logic              on_polarity;
		logic [TIME_W-1:0] on_time_ms;
		logic [TIME_W-1:0] short_gap_ms;
		logic [TIME_W-1:0] long_gap_ms;
	} cfg_t;

	typedef struct packed {
		logic lit;
		logic pin_level;
	} res_t;

endpackage

FILE: rtl/bcsl_cfg_regs.sv
module bcsl_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [bcsl_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [bcsl_pkg::CFG_DAT_W-1:0] wr_data,
	output bcsl_pkg::cfg_t                cfg,
	output logic                          clear_run
);
	import bcsl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled      <= 1'b0;
			cfg_q.on_polarity  <= 1'b1;
			cfg_q.on_time_ms   <= 16'd100;
			cfg_q.short_gap_ms <= 16'd200;
			cfg_q.long_gap_ms  <= 16'd1000;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ENABLED:   cfg_q.enabled      <= wr_data[0];
				CFG_POLARITY:  cfg_q.on_polarity  <= wr_data[0];
				CFG_ON_TIME:   cfg_q.on_time_ms   <= wr_data[TIME_W-1:0];
				CFG_SHORT_GAP: cfg_q.short_gap_ms <= wr_data[TIME_W-1:0];
				CFG_LONG_GAP:  cfg_q.long_gap_ms  <= wr_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg       = cfg_q;
	// any write to enabled restarts the indicator dark
	assign clear_run = wr_en && (wr_index == CFG_ENABLED);

endmodule

FILE: rtl/bcsl_core.sv
module bcsl_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bcsl_pkg::cfg_t              cfg,
	input  logic                        clear_run,
	input  logic                        item_en,
	input  logic                        req_type,
	input  logic [bcsl_pkg::CODE_W-1:0] status_code,
	input  logic [bcsl_pkg::TIME_W-1:0] timeout_ms,
	output bcsl_pkg::res_t              res
);
	import bcsl_pkg::*;

	logic [CODE_W-1:0]    active_code_q, code_n;
	logic [CODE_W-1:0]    pulse_index_q, idx_n;
	logic                 led_on_q, led_n;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_n, elapsed_inc;
	logic [TIME_W-1:0]    timeout_q, tmo_n;
	logic [CODE_W:0]      idx_inc;
	logic [TIME_W-1:0]    gap;

	always_comb begin
		code_n      = active_code_q;
		idx_n       = pulse_index_q;
		led_n       = led_on_q;
		elapsed_n   = elapsed_q;
		tmo_n       = timeout_q;
		idx_inc     = {1'b0, pulse_index_q} + {{CODE_W{1'b0}}, 1'b1};
		elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q
			: elapsed_q + {{(ELAPSED_W-1){1'b0}}, 1'b1};
		// last pulse of the code gets the long gap
		gap = (idx_inc == {1'b0, active_code_q}) ? cfg.long_gap_ms : cfg.short_gap_ms;
		if (item_en) begin
			if (req_type == REQ_SET) begin
				if (cfg.enabled && (status_code != active_code_q)) begin
					code_n    = status_code;
					idx_n     = '0;
					elapsed_n = '0;
					tmo_n     = timeout_ms;
					led_n     = (status_code != '0);
				end
			end else begin
				elapsed_n = elapsed_inc;
				if (cfg.enabled && (active_code_q != '0)) begin
					if ((timeout_q != '0) && (elapsed_inc > {1'b0, timeout_q})) begin
						code_n    = '0;
						idx_n     = '0;
						led_n     = 1'b0;
						elapsed_n = '0;
						tmo_n     = '0;
					end else if (led_on_q) begin
						if (elapsed_inc > {1'b0, cfg.on_time_ms}) begin
							led_n     = 1'b0;
							elapsed_n = '0;
						end
					end else if (elapsed_inc > {1'b0, gap}) begin
						led_n     = 1'b1;
						elapsed_n = '0;
						idx_n     = (idx_inc >= {1'b0, active_code_q}) ? '0 : idx_inc[CODE_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_code_q <= '0;
			pulse_index_q <= '0;
			led_on_q      <= 1'b0;
			elapsed_q     <= '0;
			timeout_q     <= '0;
		end else begin
			priority if (clear_run) begin
				active_code_q <= '0;
				pulse_index_q <= '0;
				led_on_q      <= 1'b0;
				elapsed_q     <= '0;
			end else begin
				active_code_q <= code_n;
				pulse_index_q <= idx_n;
				led_on_q      <= led_n;
				elapsed_q     <= elapsed_n;
				timeout_q     <= tmo_n;
			end
		end
	end

	// result for this item, taken by the output register
	assign res.lit       = led_n;
	assign res.pin_level = led_n ? cfg.on_polarity : ~cfg.on_polarity;

`ifndef ASSERT_OFF
	a_off_when_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		(active_code_q == '0) |-> (!led_on_q && (pulse_index_q == '0)))
		else $error("LED lit or pulse index set with no active code");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(active_code_q != '0) |-> (pulse_index_q < active_code_q))
		else $error("pulse index past active code");

	a_enable_write_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clear_run |=> (!led_on_q && (active_code_q == '0) && (elapsed_q == '0)))
		else $error("enable write did not restart indicator");

	a_toggle_clears_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		(item_en && !clear_run && (led_n != led_on_q)) |=> (elapsed_q == '0))
		else $error("LED toggled without clearing elapsed count");
`endif

endmodule

FILE: rtl/bcsl_out_reg.sv
module bcsl_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_en,
	input  bcsl_pkg::res_t                in_res,
	output logic                          in_ready,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bcsl_pkg::M_DATA_W-1:0] m_tdata
);
	import bcsl_pkg::*;

	logic valid_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_en) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_en) begin
			res_q <= in_res;
		end
	end

	assign in_ready = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(M_DATA_W-2){1'b0}}, res_q.lit, res_q.pin_level};

endmodule

FILE: rtl/blink_code_status_led.sv
// channel | dir | handshake            | payload
// s       | in  | s_tvalid / s_tready  | s_tdata: status_code, timeout_ms; s_tuser: req_type
// m       | out | m_tvalid / m_tready  | m_tdata: pin_level, lit
// cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per clock while s_tready is high: the run state updates in the accept cycle, and
// the result is registered alongside it in a single output register.
// s_tready drops only while the output register is full and m_tready is low.
// cfg_ready is always high; writes are meant for idle periods only.
// arst_n clears run state and loads the register defaults.
module blink_code_status_led (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [7:0] status_code, [23:8] timeout_ms
	input  logic [bcsl_pkg::S_DATA_W-1:0]  s_tdata,
	// [0] req_type
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] pin_level, [1] lit, [7:2] zero
	output logic [bcsl_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bcsl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bcsl_pkg::CFG_DAT_W-1:0] cfg_data
);
	import bcsl_pkg::*;

	cfg_t cfg;
	res_t res;
	logic clear_run;
	logic s_accept;

	assign cfg_ready = 1'b1;
	assign s_accept  = s_tvalid && s_tready;

	bcsl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid && cfg_ready),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.cfg       (cfg),
		.clear_run (clear_run)
	);

	bcsl_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.clear_run   (clear_run),
		.item_en     (s_accept),
		.req_type    (s_tuser),
		.status_code (s_tdata[CODE_W-1:0]),
		.timeout_ms  (s_tdata[CODE_W+TIME_W-1:CODE_W]),
		.res         (res)
	);

	bcsl_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_en    (s_accept),
		.in_res   (res),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: bench/blink_code_status_led_checker.sv
module blink_code_status_led_checker
	import bcsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// [7:0] status_code, [23:8] timeout_ms
	input  logic [S_DATA_W-1:0]   s_tdata,
	// [0] req_type
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] pin_level, [1] lit, [7:2] zero
	input  logic [M_DATA_W-1:0]   m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data,
	output int                    pending,
	output int                    fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [TIME_W-1:0] DEF_ON_TIME   = 16'd100;
	localparam logic [TIME_W-1:0] DEF_SHORT_GAP = 16'd200;
	localparam logic [TIME_W-1:0] DEF_LONG_GAP  = 16'd1000;

	cfg_t                 regs;
	logic [CODE_W-1:0]    active_code;
	logic [CODE_W-1:0]    pulse_idx;
	logic                 led_lit;
	logic [ELAPSED_W-1:0] elapsed;
	logic [TIME_W-1:0]    tmo_limit;
	res_t                 led_expected[$];

	task automatic clear_blink_run();
		active_code = '0;
		pulse_idx   = '0;
		led_lit     = 1'b0;
		elapsed     = '0;
	endtask

	task automatic load_code(input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] tmo);
		if (code != active_code && regs.enabled) begin
			active_code = code;
			pulse_idx   = '0;
			elapsed     = '0;
			tmo_limit   = tmo;
			led_lit     = (code != '0);
		end
	endtask

	task automatic blink_tick();
		logic [TIME_W-1:0] gap;
		if (elapsed != ELAPSED_MAX)
			elapsed = elapsed + 1'b1;
		if (!regs.enabled || active_code == '0)
			return;
		// auto-off wins over any toggle in the same tick
		if (tmo_limit != '0 && elapsed > tmo_limit) begin
			load_code('0, '0);
			return;
		end
		if (led_lit) begin
			if (elapsed > regs.on_time_ms) begin
				led_lit = 1'b0;
				elapsed = '0;
			end
		end else begin
			gap = (int'(pulse_idx) + 1 == int'(active_code)) ? regs.long_gap_ms
				: regs.short_gap_ms;
			if (elapsed > gap) begin
				led_lit   = 1'b1;
				elapsed   = '0;
				pulse_idx = pulse_idx + 1'b1;
				if (pulse_idx >= active_code)
					pulse_idx = '0;
			end
		end
	endtask

	task automatic write_shadow(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
		case (idx)
			CFG_ENABLED: begin
				regs.enabled = d[0];
				clear_blink_run();
			end
			CFG_POLARITY:  regs.on_polarity  = d[0];
			CFG_ON_TIME:   regs.on_time_ms   = d;
			CFG_SHORT_GAP: regs.short_gap_ms = d;
			CFG_LONG_GAP:  regs.long_gap_ms  = d;
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			regs.enabled      = 1'b0;
			regs.on_polarity  = 1'b1;
			regs.on_time_ms   = DEF_ON_TIME;
			regs.short_gap_ms = DEF_SHORT_GAP;
			regs.long_gap_ms  = DEF_LONG_GAP;
			clear_blink_run();
			tmo_limit = '0;
			led_expected.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// pop first: a result always belongs to an earlier item
			if (m_tvalid && m_tready) begin
				if (led_expected.size() == 0) begin
					$display("%0t: result with nothing expected, actual m_tdata %h",
						$realtime, m_tdata);
					fail_count++;
				end else begin
					want = led_expected.pop_front();
					if (m_tdata[0] !== want.pin_level) begin
						$display("%0t: pin_level expected %0b actual %0b",
							$realtime, want.pin_level, m_tdata[0]);
						fail_count++;
					end
					if (m_tdata[1] !== want.lit) begin
						$display("%0t: lit expected %0b actual %0b",
							$realtime, want.lit, m_tdata[1]);
						fail_count++;
					end
					if (m_tdata[M_DATA_W-1:2] !== '0) begin
						$display("%0t: m_tdata pad expected 0 actual %h",
							$realtime, m_tdata[M_DATA_W-1:2]);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				write_shadow(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				if (s_tuser == REQ_SET)
					load_code(s_tdata[CODE_W-1:0], s_tdata[CODE_W+TIME_W-1:CODE_W]);
				else
					blink_tick();
				want.lit       = led_lit;
				want.pin_level = led_lit ? regs.on_polarity : ~regs.on_polarity;
				led_expected.push_back(want);
			end
			pending <= led_expected.size();
		end
	end

endmodule

FILE: bench/blink_code_status_led_tb.sv
module blink_code_status_led_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bcsl_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 112;
	localparam int CFG_IDX_TOP     = (1 << CFG_IDX_W) - 1;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	int pending;
	int fail_count;
	int idle_cycles;
	bit src_steady;
	bit sink_steady;

	blink_code_status_led DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	blink_code_status_led_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [TIME_W-1:0] pick_dur();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return TIME_W'($urandom_range(0, 6));
		else if (r < 9)
			return TIME_W'($urandom_range(0, 40));
		return {TIME_W{1'b1}};
	endfunction

	function automatic logic [TIME_W-1:0] pick_timeout();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return '0;
		else if (r < 85)
			return TIME_W'($urandom_range(1, 30));
		return TIME_W'($urandom);
	endfunction

	// sink side stalls
	initial begin
		int  hold;
		logic lvl;
		hold = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				lvl  = sink_steady || ($urandom_range(0, 99) < 70);
				hold = pick_gap();
				m_tready <= lvl;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("blink_code_status_led_tb NOT OK");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_item(input logic kind, input logic [CODE_W-1:0] code,
		input logic [TIME_W-1:0] tmo);
		int gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {tmo, code};
		do @(posedge clk); while (!s_tready);
	endtask

	// tick with junk payload so the ignored bits toggle too
	task automatic send_tick();
		send_item(REQ_TICK, CODE_W'($urandom), TIME_W'($urandom));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// leaves cfg_valid high; caller lowers it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	initial begin
		int r;
		logic [CFG_DAT_W-1:0] d;
		idle_cycles = 0;
		src_steady  = 1'b0;
		sink_steady = 1'b0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= REQ_TICK;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ENABLED;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: ticks hold the LED dark, sets are dropped
		send_tick();
		send_item(REQ_SET, 8'd3, '0);
		drain_results();

		write_reg(CFG_ON_TIME, 16'd1);
		write_reg(CFG_SHORT_GAP, 16'd1);
		write_reg(CFG_LONG_GAP, 16'd2);
		write_reg(CFG_ENABLED, 16'd1);
		cfg_valid <= 1'b0;

		// two pulses: on, short gap, on, long gap, back to first pulse
		send_item(REQ_SET, 8'd2, '0);
		repeat (9) send_tick();
		send_item(REQ_SET, 8'd2, 16'd7);	// same code, dropped
		send_item(REQ_SET, 8'd0, '0);	// off at once
		send_tick();
		send_item(REQ_SET, 8'hFF, 16'hFFFF);
		send_tick();
		drain_results();

		// long lit phase so the auto-off fires first
		write_reg(CFG_POLARITY, 16'd0);
		write_reg(CFG_ON_TIME, 16'hFFFF);
		write_reg(CFG_SHORT_GAP, 16'd0);
		write_reg(CFG_LONG_GAP, 16'hFFFF);
		cfg_valid <= 1'b0;
		send_item(REQ_SET, 8'd1, 16'd3);
		repeat (4) send_tick();
		send_item(REQ_SET, 8'd1, '0);
		repeat (2) send_tick();

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			if (ph == 0) begin
				write_reg(CFG_ON_TIME, '0);
				write_reg(CFG_SHORT_GAP, '0);
				write_reg(CFG_LONG_GAP, '0);
			end else if (ph == 1) begin
				write_reg(CFG_POLARITY, 16'd1);
				write_reg(CFG_ON_TIME, 16'd1);
				write_reg(CFG_SHORT_GAP, 16'hFFFF);
				write_reg(CFG_LONG_GAP, 16'd3);
			end else begin
				if ($urandom_range(0, 1))
					write_reg(CFG_POLARITY, CFG_DAT_W'($urandom));
				write_reg(CFG_ON_TIME, pick_dur());
				write_reg(CFG_SHORT_GAP, pick_dur());
				write_reg(CFG_LONG_GAP, pick_dur());
			end
			if (ph == 2 || ph == 3 || $urandom_range(0, 1)) begin
				d    = CFG_DAT_W'($urandom);
				d[0] = (ph != 2);
				write_reg(CFG_ENABLED, d);
			end
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_IDX_W'($urandom_range(CFG_LONG_GAP + 1, CFG_IDX_TOP)),
					CFG_DAT_W'($urandom));
			cfg_valid <= 1'b0;

			src_steady  = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					drain_results();
				r = $urandom_range(0, 99);
				if (r < 70)
					send_tick();
				else if (r < 92)
					send_item(REQ_SET, CODE_W'($urandom_range(0, 5)), pick_timeout());
				else
					send_item(REQ_SET, CODE_W'($urandom), TIME_W'($urandom));
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("blink_code_status_led_tb OK");
		else
			$display("blink_code_status_led_tb NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bcsl_pkg.sv
rtl/bcsl_cfg_regs.sv
rtl/bcsl_core.sv
rtl/bcsl_out_reg.sv
rtl/blink_code_status_led.sv
bench/blink_code_status_led_checker.sv
bench/blink_code_status_led_tb.sv
